### hdl/nnds_pkg.sv
// Shared types and constants for the nearest-neighbor dispersal stencil.
// No dependencies; every other file of the block uses this package.
package nnds_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DELTA_BITS    = 16;
    localparam int DELTA_W       = 15;
    localparam int COUNT_W       = 32;
    localparam int MEAN_W        = 32;
    localparam int TOTAL_W       = 48;
    localparam int GAIN_W        = 31;
    localparam int WIDE_W        = 64;

    localparam logic [1:0] SEEN_NONE  = 2'd0;
    localparam logic [1:0] SEEN_FIRST = 2'd1;
    localparam logic [1:0] SEEN_MID   = 2'd2;

    typedef struct packed {
        logic        [COUNT_W-1:0] count;
        logic signed [MEAN_W-1:0]  trait_mean;
        logic signed [TOTAL_W-1:0] trait_total;
        logic signed [MEAN_W-1:0]  breed_mean;
        logic signed [TOTAL_W-1:0] breed_total;
    } cell_t;

    typedef struct packed {
        logic capture;
        logic store1;
        logic shift;
        logic load;
        logic src_x;
        logic has_l;
        logic has_r;
        logic last;
        logic div_start;
        logic put;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

endpackage

### hdl/nnds_if.sv
// Valid/ready channel interfaces for cell input and cell result.
// Depends on nnds_pkg for field widths.
interface nnds_in_if;
    logic                                 valid;
    logic                                 ready;
    logic        [nnds_pkg::COUNT_W-1:0]  in_count;
    logic signed [nnds_pkg::MEAN_W-1:0]   in_trait_mean;
    logic signed [nnds_pkg::TOTAL_W-1:0]  in_trait_total;
    logic signed [nnds_pkg::MEAN_W-1:0]   in_breed_mean;
    logic signed [nnds_pkg::TOTAL_W-1:0]  in_breed_total;
    logic                                 in_last;

    modport source (output valid, in_count, in_trait_mean, in_trait_total, in_breed_mean,
                    in_breed_total, in_last, input ready);
    modport sink (input valid, in_count, in_trait_mean, in_trait_total, in_breed_mean,
                  in_breed_total, in_last, output ready);
endinterface

interface nnds_out_if;
    logic                                 valid;
    logic                                 ready;
    logic        [nnds_pkg::COUNT_W-1:0]  out_count;
    logic signed [nnds_pkg::MEAN_W-1:0]   out_trait_mean;
    logic signed [nnds_pkg::TOTAL_W-1:0]  out_trait_total;
    logic signed [nnds_pkg::MEAN_W-1:0]   out_breed_mean;
    logic signed [nnds_pkg::TOTAL_W-1:0]  out_breed_total;
    logic                                 out_empty;
    logic                                 out_last;

    modport source (output valid, out_count, out_trait_mean, out_trait_total, out_breed_mean,
                    out_breed_total, out_empty, out_last, input ready);
    modport sink (input valid, out_count, out_trait_mean, out_trait_total, out_breed_mean,
                  out_breed_total, out_empty, out_last, output ready);
endinterface

### hdl/nnds_div.sv
// Radix-4 restoring divider: saturated mean = total * 2^F / count, truncated.
// Depends on nnds_pkg.
module nnds_div #(
    parameter int FRAC_BITS = nnds_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [nnds_pkg::TOTAL_W-1:0] total,
    input  logic        [nnds_pkg::COUNT_W-1:0] divisor,
    output logic                                done,
    output logic signed [nnds_pkg::MEAN_W-1:0]  mean
);
    localparam int QW    = nnds_pkg::COUNT_W;
    localparam int TW    = nnds_pkg::TOTAL_W;
    localparam int STEPS = QW / 2;
    localparam int CW    = $clog2(STEPS);

    logic [QW-1:0] r_reg, r_next, q_reg, q_next, d_reg;
    logic          neg_reg, sat_reg, busy_reg, busy_next, done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [TW-1:0] mag, rinit;
    logic [QW:0]   r1, r2;
    logic [QW-1:0] r1n, lim, qmag;
    logic          ge1, ge2, over;

    always_comb
    begin
        mag   = total[TW-1] ? TW'(-total) : TW'(total);
        rinit = mag >> (QW - FRAC_BITS);
        r1    = {r_reg, q_reg[QW-1]};
        ge1   = r1 >= {1'b0, d_reg};
        r1n   = ge1 ? QW'(r1 - {1'b0, d_reg}) : r1[QW-1:0];
        r2    = {r1n, q_reg[QW-2]};
        ge2   = r2 >= {1'b0, d_reg};
        r_next    = r_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            r_next    = rinit[QW-1:0];
            q_next    = QW'(mag << FRAC_BITS);
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            r_next   = ge2 ? QW'(r2 - {1'b0, d_reg}) : r2[QW-1:0];
            q_next   = {q_reg[QW-3:0], ge1, ge2};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
        if (start)
        begin
            d_reg   <= divisor;
            neg_reg <= total[TW-1];
            sat_reg <= {{(TW-QW){1'b0}}, divisor} <= rinit;
        end
    end

    always_comb
    begin
        lim  = neg_reg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        over = sat_reg || (q_reg > lim);
        qmag = over ? lim : q_reg;
        mean = neg_reg ? $signed(QW'(-qmag)) : $signed(qmag);
    end

    assign done = done_reg;

endmodule

### hdl/nnds_datapath.sv
// Datapath: cell window, exchange arithmetic, two mean dividers, result register.
// Depends on nnds_pkg and nnds_div.
module nnds_datapath #(
    parameter int FRAC_BITS = nnds_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  nnds_pkg::cmd_t                     cmd,
    output nnds_pkg::stat_t                    stat,
    input  logic [nnds_pkg::DELTA_W-1:0]       delta,
    input  nnds_pkg::cell_t                    x_in,
    output nnds_pkg::cell_t                    res,
    output logic                               res_empty,
    output logic                               res_last
);
    localparam int GW = nnds_pkg::GAIN_W;
    localparam int WW = nnds_pkg::WIDE_W;
    localparam int TW = nnds_pkg::TOTAL_W;
    localparam int CW = nnds_pkg::COUNT_W;
    localparam int PW = nnds_pkg::DELTA_W + CW;

    function automatic logic signed [WW-1:0] share_f(input logic [GW-1:0] g,
                                                     input logic signed [31:0] m);
        logic signed [WW-1:0] p;
        p = $signed({1'b0, g}) * m;
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic signed [TW-1:0] sat_f(input logic signed [WW-1:0] v);
        if (v[WW-1:TW-1] == '0 || v[WW-1:TW-1] == '1)
            return v[TW-1:0];
        return v[WW-1] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    endfunction

    nnds_pkg::cell_t x_reg, w0_reg, w1_reg, s_reg, l_reg, r_reg, res_reg;
    logic hl_reg, hr_reg, last_reg, empty_reg, olast_reg;
    logic [GW-1:0] loss_reg, gl_reg, gr_reg;
    logic [PW-1:0] ml, mgl, mgr;
    logic signed [WW-1:0] zs_reg, as_reg, zl_reg, al_reg, zr_reg, ar_reg;
    logic [CW+1:0] nsum_reg;
    logic [CW-1:0] nc_reg;
    logic signed [TW-1:0] tz_reg, ta_reg;
    logic signed [WW-1:0] tz, ta;
    logic done_z, done_a;
    logic signed [31:0] mz, ma;
    nnds_pkg::cell_t fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg <= '0;
            w1_reg <= '0;
        end
        else if (cmd.shift)
        begin
            w0_reg <= w1_reg;
            w1_reg <= x_reg;
        end
        else if (cmd.store1)
        begin
            w1_reg <= x_reg;
        end
    end

    always_comb
    begin
        ml  = PW'(delta) * PW'(s_reg.count);
        mgl = PW'(delta) * PW'(l_reg.count);
        mgr = PW'(delta) * PW'(r_reg.count);
        tz  = WW'(s_reg.trait_total) + (hl_reg ? zl_reg - zs_reg : '0)
              + (hr_reg ? zr_reg - zs_reg : '0);
        ta  = WW'(s_reg.breed_total) + (hl_reg ? al_reg - as_reg : '0)
              + (hr_reg ? ar_reg - as_reg : '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            x_reg <= x_in;
        if (cmd.load)
        begin
            s_reg    <= cmd.src_x ? x_reg : w1_reg;
            l_reg    <= w0_reg;
            r_reg    <= x_reg;
            hl_reg   <= cmd.has_l;
            hr_reg   <= cmd.has_r;
            last_reg <= cmd.last;
        end
        loss_reg <= ml[PW-1:nnds_pkg::DELTA_BITS];
        gl_reg   <= mgl[PW-1:nnds_pkg::DELTA_BITS];
        gr_reg   <= mgr[PW-1:nnds_pkg::DELTA_BITS];
        zs_reg   <= share_f(loss_reg, s_reg.trait_mean);
        as_reg   <= share_f(loss_reg, s_reg.breed_mean);
        zl_reg   <= share_f(gl_reg, l_reg.trait_mean);
        al_reg   <= share_f(gl_reg, l_reg.breed_mean);
        zr_reg   <= share_f(gr_reg, r_reg.trait_mean);
        ar_reg   <= share_f(gr_reg, r_reg.breed_mean);
        nsum_reg <= {2'b00, s_reg.count}
                    + (hl_reg ? (CW+2)'(gl_reg) - (CW+2)'(loss_reg) : '0)
                    + (hr_reg ? (CW+2)'(gr_reg) - (CW+2)'(loss_reg) : '0);
        nc_reg   <= (nsum_reg[CW+1:CW] != 2'b00) ? '1 : nsum_reg[CW-1:0];
        tz_reg   <= sat_f(tz);
        ta_reg   <= sat_f(ta);
        if (cmd.put)
        begin
            res_reg   <= fin;
            empty_reg <= fin.count == '0;
            olast_reg <= last_reg;
        end
    end

    nnds_div #(.FRAC_BITS(FRAC_BITS)) u_div_trait (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .total(tz_reg),
        .divisor(nc_reg), .done(done_z), .mean(mz)
    );

    nnds_div #(.FRAC_BITS(FRAC_BITS)) u_div_breed (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .total(ta_reg),
        .divisor(nc_reg), .done(done_a), .mean(ma)
    );

    always_comb
    begin
        if (delta == '0)
            fin = s_reg;
        else
        begin
            fin.count       = nc_reg;
            fin.trait_total = tz_reg;
            fin.breed_total = ta_reg;
            fin.trait_mean  = mz;
            fin.breed_mean  = ma;
        end
        if (fin.count == '0)
        begin
            fin.trait_mean = '0;
            fin.breed_mean = '0;
        end
    end

    assign stat.div_done = done_z & done_a;
    assign res       = res_reg;
    assign res_empty = empty_reg;
    assign res_last  = olast_reg;

endmodule

### hdl/nnds_ctrl.sv
// Controller: sequences window updates, arithmetic stages, divides and output.
// Depends on nnds_pkg.
module nnds_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    output logic            in_ready,
    input  logic            out_ready,
    output logic            out_valid,
    output nnds_pkg::cmd_t  cmd,
    input  nnds_pkg::stat_t stat
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_PROD  = 8'b0000_1000,
        S_SUM   = 8'b0001_0000,
        S_START = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_PUT   = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] seen_reg, seen_next;
    logic       last_reg, last_next, sec_reg, sec_next, valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        last_next  = last_reg;
        sec_next   = sec_reg;
        cmd        = '0;
        cmd.capture = in_valid && state_reg == S_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next  = in_last;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (seen_reg == nnds_pkg::SEEN_NONE)
                begin
                    cmd.store1 = 1'b1;
                    if (last_reg)
                    begin
                        cmd.load   = 1'b1;
                        cmd.src_x  = 1'b1;
                        cmd.last   = 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        seen_next  = nnds_pkg::SEEN_FIRST;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.load   = 1'b1;
                    cmd.has_l  = seen_reg == nnds_pkg::SEEN_MID;
                    cmd.has_r  = 1'b1;
                    cmd.shift  = 1'b1;
                    sec_next   = last_reg;
                    seen_next  = last_reg ? nnds_pkg::SEEN_NONE : nnds_pkg::SEEN_MID;
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_PROD;
            S_PROD:  state_next = S_SUM;
            S_SUM:   state_next = S_START;
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_PUT;
            end
            S_PUT:
            begin
                if (!valid_reg || out_ready)
                begin
                    cmd.put = 1'b1;
                    if (sec_reg)
                    begin
                        cmd.load   = 1'b1;
                        cmd.has_l  = 1'b1;
                        cmd.last   = 1'b1;
                        sec_next   = 1'b0;
                        state_next = S_MUL;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        valid_next = cmd.put ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seen_reg  <= nnds_pkg::SEEN_NONE;
            last_reg  <= 1'b0;
            sec_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            last_reg  <= last_next;
            sec_reg   <= sec_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = valid_reg;

endmodule

### hdl/nearest_neighbor_dispersal_stencil.sv
// Top level of the nearest-neighbor dispersal stencil.
// Depends on nnds_pkg, nnds_if, nnds_ctrl and nnds_datapath.
//
// Usage: cells of a 1-D landscape enter on cell_in in order, in_last on the
// final one. Each result leaves on cell_out when the right neighbor of its
// cell arrives; the final cell produces two results (one for a single cell).
// cfg_we/cfg_wdata write delta_rate (Q0.16, 15 bits wide, so below 0.5);
// the user must write it only while the block is idle; nothing enforces it.
// For each result the controller loads the window, steps through the
// multiply, product and sum stages, starts the two radix-4 mean dividers,
// which work in parallel, and puts the result; a final cell with a left
// neighbor runs them twice. The next cell is taken only after the put.
// The output register holds a finished result while the receiver stalls;
// the next cell is taken meanwhile, and its result waits until it is free.
// Reset clears the window, delta_rate and all handshakes.
module nearest_neighbor_dispersal_stencil #(
    parameter int FRAC_BITS = nnds_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    nnds_in_if.sink                         cell_in,
    nnds_out_if.source                      cell_out,
    input  logic                            cfg_we,
    input  logic [nnds_pkg::DELTA_W-1:0]    cfg_wdata
);
    nnds_pkg::cmd_t  cmd;
    nnds_pkg::stat_t stat;
    nnds_pkg::cell_t x_in, res;
    logic [nnds_pkg::DELTA_W-1:0] delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delta_reg <= '0;
        else if (cfg_we)
            delta_reg <= cfg_wdata;
    end

    assign x_in.count       = cell_in.in_count;
    assign x_in.trait_mean  = cell_in.in_trait_mean;
    assign x_in.trait_total = cell_in.in_trait_total;
    assign x_in.breed_mean  = cell_in.in_breed_mean;
    assign x_in.breed_total = cell_in.in_breed_total;

    nnds_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(cell_in.valid), .in_last(cell_in.in_last),
        .in_ready(cell_in.ready), .out_ready(cell_out.ready), .out_valid(cell_out.valid),
        .cmd(cmd), .stat(stat)
    );

    nnds_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .delta(delta_reg),
        .x_in(x_in), .res(res), .res_empty(cell_out.out_empty),
        .res_last(cell_out.out_last)
    );

    assign cell_out.out_count       = res.count;
    assign cell_out.out_trait_mean  = res.trait_mean;
    assign cell_out.out_trait_total = res.trait_total;
    assign cell_out.out_breed_mean  = res.breed_mean;
    assign cell_out.out_breed_total = res.breed_total;

endmodule

### hdl/nnds_chk.sv
// Port-level checker for the dispersal stencil, bound to the top level.
// Depends on nnds_pkg.
module nnds_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [nnds_pkg::COUNT_W-1:0]       out_count,
    input logic [nnds_pkg::MEAN_W-1:0]        out_trait_mean,
    input logic [nnds_pkg::MEAN_W-1:0]        out_breed_mean,
    input logic                               out_empty
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_count) && $stable(out_trait_mean))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_empty == (out_count == '0))
        else $error("empty flag disagrees with count");

    a_empty_means: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_empty |-> out_trait_mean == '0 && out_breed_mean == '0)
        else $error("empty cell carries a mean");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too soon after transfer");
endmodule

bind nearest_neighbor_dispersal_stencil nnds_chk u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(cell_in.valid), .in_ready(cell_in.ready),
    .out_valid(cell_out.valid), .out_ready(cell_out.ready), .out_count(cell_out.out_count),
    .out_trait_mean(cell_out.out_trait_mean), .out_breed_mean(cell_out.out_breed_mean),
    .out_empty(cell_out.out_empty)
);

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for nearest_neighbor_dispersal_stencil: directed cells, then random
// landscapes under several dispersal rates and handshake idling patterns.
// Depends on nnds_pkg, nnds_if and the block's RTL.
module testbench;

    localparam int FRAC = nnds_pkg::FRAC_BITS_DEF;
    localparam int DW   = nnds_pkg::DELTA_W;
    localparam longint COUNT_MAX = 64'hFFFF_FFFF;
    localparam longint TOTAL_MAX = (64'sd1 <<< 47) - 1;
    localparam longint TOTAL_MIN = -(64'sd1 <<< 47);
    localparam logic [DW-1:0] DELTA_TOP  = '1;
    localparam logic [DW-1:0] DELTA_ZERO = '0;
    localparam logic [DW-1:0] DELTA_ONE  = DW'(1);

    typedef struct packed {
        logic        [nnds_pkg::COUNT_W-1:0] count;
        logic signed [nnds_pkg::MEAN_W-1:0]  trait_mean;
        logic signed [nnds_pkg::TOTAL_W-1:0] trait_total;
        logic signed [nnds_pkg::MEAN_W-1:0]  breed_mean;
        logic signed [nnds_pkg::TOTAL_W-1:0] breed_total;
        logic                                empty;
        logic                                last;
    } dispersed_t;

    typedef struct {
        logic [DW-1:0]   delta;
        nnds_pkg::cell_t stim;
        logic            last;
        logic            typed;
        dispersed_t      result;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [DW-1:0] cfg_wdata;

    nnds_in_if  cell_in_bus ();
    nnds_out_if cell_out_bus ();

    nearest_neighbor_dispersal_stencil DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_in   (cell_in_bus),
        .cell_out  (cell_out_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    nnds_pkg::cell_t    window [2];
    logic [1:0]         cells_seen;
    logic [DW-1:0]      delta_rate;
    dispersed_t         pending_results [$];
    int                 mismatches;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 phase_num;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint floor_frac(longint p);
        return p >>> FRAC;
    endfunction

    function automatic logic [nnds_pkg::MEAN_W-1:0] mean_from(longint total, longint cnt);
        logic   neg;
        longint mag;
        longint quo;
        longint rem;
        longint lim;
        longint m;
        neg = total < 0;
        mag = neg ? -total : total;
        quo = mag / cnt;
        rem = mag % cnt;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (quo >= (64'sd1 <<< (32 - FRAC)))
            m = lim;
        else
            m = (quo <<< FRAC) + ((rem <<< FRAC) / cnt);
        if (m > lim)
            m = lim;
        return neg ? -m : m;
    endfunction

    function automatic dispersed_t disperse_cell(nnds_pkg::cell_t s, logic has_l,
                                                 nnds_pkg::cell_t l, logic has_r,
                                                 nnds_pkg::cell_t r, logic last);
        nnds_pkg::cell_t nb [2];
        logic       has [2];
        longint     n;
        longint     zt;
        longint     at;
        longint     zm;
        longint     am;
        longint     loss;
        longint     gain;
        dispersed_t res;
        n = s.count;
        zt = $signed(s.trait_total);
        at = $signed(s.breed_total);
        zm = $signed(s.trait_mean);
        am = $signed(s.breed_mean);
        nb[0] = l;
        nb[1] = r;
        has[0] = has_l;
        has[1] = has_r;
        if (delta_rate != 0)
        begin
            loss = (longint'(delta_rate) * n) >> nnds_pkg::DELTA_BITS;
            for (int i = 0; i < 2; i++)
            begin
                if (has[i])
                begin
                    gain = (longint'(delta_rate) * longint'(nb[i].count))
                           >> nnds_pkg::DELTA_BITS;
                    n = n + gain - loss;
                    zt += floor_frac(gain * longint'($signed(nb[i].trait_mean)))
                          - floor_frac(loss * longint'($signed(s.trait_mean)));
                    at += floor_frac(gain * longint'($signed(nb[i].breed_mean)))
                          - floor_frac(loss * longint'($signed(s.breed_mean)));
                end
            end
            if (n > COUNT_MAX)
                n = COUNT_MAX;
            zt = (zt > TOTAL_MAX) ? TOTAL_MAX : (zt < TOTAL_MIN) ? TOTAL_MIN : zt;
            at = (at > TOTAL_MAX) ? TOTAL_MAX : (at < TOTAL_MIN) ? TOTAL_MIN : at;
            if (n != 0)
            begin
                zm = $signed(mean_from(zt, n));
                am = $signed(mean_from(at, n));
            end
        end
        if (n == 0)
        begin
            zm = 0;
            am = 0;
        end
        res.count = n[nnds_pkg::COUNT_W-1:0];
        res.trait_mean = zm[nnds_pkg::MEAN_W-1:0];
        res.trait_total = zt[nnds_pkg::TOTAL_W-1:0];
        res.breed_mean = am[nnds_pkg::MEAN_W-1:0];
        res.breed_total = at[nnds_pkg::TOTAL_W-1:0];
        res.empty = (n == 0);
        res.last = last;
        return res;
    endfunction

    function automatic void accept_cell(nnds_pkg::cell_t c, logic last);
        nnds_pkg::cell_t prev;
        if (cells_seen == nnds_pkg::SEEN_NONE)
        begin
            window[1] = c;
            if (last)
                pending_results.push_back(disperse_cell(c, 1'b0, c, 1'b0, c, 1'b1));
            else
                cells_seen = nnds_pkg::SEEN_FIRST;
        end
        else
        begin
            prev = window[1];
            pending_results.push_back(disperse_cell(prev, cells_seen == nnds_pkg::SEEN_MID,
                                                    window[0], 1'b1, c, 1'b0));
            window[0] = prev;
            window[1] = c;
            if (last)
            begin
                pending_results.push_back(disperse_cell(c, 1'b1, prev, 1'b0, c, 1'b1));
                cells_seen = nnds_pkg::SEEN_NONE;
            end
            else
                cells_seen = nnds_pkg::SEEN_MID;
        end
    endfunction

    function automatic nnds_pkg::cell_t make_cell(logic [31:0] n, logic [31:0] zm,
                                                  logic [47:0] zt, logic [31:0] am,
                                                  logic [47:0] at);
        nnds_pkg::cell_t c;
        c.count = n;
        c.trait_mean = zm;
        c.trait_total = zt;
        c.breed_mean = am;
        c.breed_total = at;
        return c;
    endfunction

    function automatic dispersed_t make_result(logic [31:0] n, logic [31:0] zm, logic [47:0] zt,
                                               logic [31:0] am, logic [47:0] at, logic empty);
        dispersed_t r;
        r.count = n;
        r.trait_mean = zm;
        r.trait_total = zt;
        r.breed_mean = am;
        r.breed_total = at;
        r.empty = empty;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic dir_row_t make_row(logic [DW-1:0] d, nnds_pkg::cell_t c, logic last);
        dir_row_t row;
        row.delta = d;
        row.stim = c;
        row.last = last;
        row.typed = 1'b0;
        row.result = '0;
        return row;
    endfunction

    function automatic logic [31:0] rand_mean();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [47:0] rand_total();
        logic [47:0] t;
        case ($urandom_range(0, 5))
            0: t = 48'h8000_0000_0000;
            1: t = 48'h7FFF_FFFF_FFFF;
            2: t = {8'h00, 8'($urandom_range(0, 255)), $urandom} - 48'h80_0000_0000;
            default: t = {16'($urandom_range(0, 16'hFFFF)), $urandom};
        endcase
        return t;
    endfunction

    function automatic nnds_pkg::cell_t rand_cell();
        logic [31:0] n;
        case ($urandom_range(0, 9))
            0: n = 0;
            1: n = 32'hFFFF_FFFF;
            2, 3: n = $urandom_range(0, 32'h3_FFFF);
            default: n = $urandom;
        endcase
        return make_cell(n, rand_mean(), rand_total(), rand_mean(), rand_total());
    endfunction

    task automatic send_cell(nnds_pkg::cell_t c, logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cell_in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cell_in_bus.valid <= 1'b1;
        cell_in_bus.in_count <= c.count;
        cell_in_bus.in_trait_mean <= c.trait_mean;
        cell_in_bus.in_trait_total <= c.trait_total;
        cell_in_bus.in_breed_mean <= c.breed_mean;
        cell_in_bus.in_breed_total <= c.breed_total;
        cell_in_bus.in_last <= last;
        do
            @(posedge clk);
        while (!cell_in_bus.ready);
        accept_cell(c, last);
    endtask

    task automatic drain_results();
        @(negedge clk);
        cell_in_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_delta(logic [DW-1:0] d);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        delta_rate = d;
    endtask

    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        cell_out_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (phase_num == 4 && !held)
            begin
                held = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                cell_out_bus.ready <= 1'b0;
            end
            else
                cell_out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        dispersed_t got;
        dispersed_t want;
        if (rst_n && cell_out_bus.valid && cell_out_bus.ready)
        begin
            got.count = cell_out_bus.out_count;
            got.trait_mean = cell_out_bus.out_trait_mean;
            got.trait_total = cell_out_bus.out_trait_total;
            got.breed_mean = cell_out_bus.out_breed_mean;
            got.breed_total = cell_out_bus.out_breed_total;
            got.empty = cell_out_bus.out_empty;
            got.last = cell_out_bus.out_last;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected n=%h zm=%h zt=%h am=%h at=%h e=%b l=%b\n"
                                 , want.count, want.trait_mean, want.trait_total,
                                 want.breed_mean, want.breed_total, want.empty, want.last,
                                 "          actual   n=%h zm=%h zt=%h am=%h at=%h e=%b l=%b",
                                 got.count, got.trait_mean, got.trait_total,
                                 got.breed_mean, got.breed_total, got.empty, got.last);
                end
            end
        end
    end

    initial
    begin
        dir_row_t     dir_rows [$];
        dir_row_t     row;
        int           len;
        int           sent;
        logic [DW-1:0] phase_delta [8];

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        cell_in_bus.valid = 1'b0;
        cell_in_bus.in_count = '0;
        cell_in_bus.in_trait_mean = '0;
        cell_in_bus.in_trait_total = '0;
        cell_in_bus.in_breed_mean = '0;
        cell_in_bus.in_breed_total = '0;
        cell_in_bus.in_last = 1'b0;
        phase_num = -1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        delta_rate = '0;
        cells_seen = nnds_pkg::SEEN_NONE;
        window[0] = '0;
        window[1] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        row = make_row(DELTA_ZERO, make_cell(0, 32'h1234_5678, 48'h7FFF_FFFF_FFFF,
                                             32'hFFFF_FFFF, 48'h8000_0000_0000), 1'b1);
        row.typed = 1'b1;
        row.result = make_result(0, 0, 48'h7FFF_FFFF_FFFF, 0, 48'h8000_0000_0000, 1'b1);
        dir_rows.push_back(row);
        row = make_row(DELTA_ZERO, make_cell(32'hFFFF_FFFF, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF,
                                             32'h8000_0000, 48'h8000_0000_0000), 1'b1);
        row.typed = 1'b1;
        row.result = make_result(32'hFFFF_FFFF, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF,
                                 32'h8000_0000, 48'h8000_0000_0000, 1'b0);
        dir_rows.push_back(row);
        row = make_row(DELTA_ZERO, make_cell(1, 32'h8000_0000, 48'h8000_0000_0000,
                                             32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF), 1'b1);
        row.typed = 1'b1;
        row.result = make_result(1, 32'h8000_0000, 48'h8000_0000_0000, 32'h7FFF_FFFF,
                                 48'h7FFF_FFFF_FFFF, 1'b0);
        dir_rows.push_back(row);
        dir_rows.push_back(make_row(DELTA_ZERO, make_cell(32'h0002_0000, 32'h0001_0000,
                           48'h2_0000, 32'hFFFF_0000, 48'hFFFF_FFFE_0000), 1'b0));
        dir_rows.push_back(make_row(DELTA_ZERO, make_cell(0, 32'h0005_0000, 48'h0, 0, 48'h0),
                                    1'b1));
        row = make_row(DELTA_TOP, make_cell(32'h0001_0000, 0, 48'h3_0000, 0,
                                            48'hFFFF_FFFE_0000), 1'b1);
        row.typed = 1'b1;
        row.result = make_result(32'h0001_0000, 32'h0003_0000, 48'h3_0000, 32'hFFFE_0000,
                                 48'hFFFF_FFFE_0000, 1'b0);
        dir_rows.push_back(row);
        row = make_row(DELTA_TOP, make_cell(1, 0, 48'h7FFF_FFFF_FFFF, 0,
                                            48'h8000_0000_0000), 1'b1);
        row.typed = 1'b1;
        row.result = make_result(1, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 32'h8000_0000,
                                 48'h8000_0000_0000, 1'b0);
        dir_rows.push_back(row);
        dir_rows.push_back(make_row(DELTA_TOP, make_cell(32'hFFFF_FFFF, 32'h7FFF_FFFF,
                           48'h7FFF_FFFF_FFFF, 32'h8000_0000, 48'h8000_0000_0000), 1'b0));
        dir_rows.push_back(make_row(DELTA_TOP, make_cell(0, 32'h8000_0000, 48'h8000_0000_0000,
                           32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF), 1'b0));
        dir_rows.push_back(make_row(DELTA_TOP, make_cell(32'hFFFF_FFFF, 32'h7FFF_FFFF,
                           48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF), 1'b0));
        dir_rows.push_back(make_row(DELTA_TOP, make_cell(32'h0000_0100, 32'h8000_0000,
                           48'h8000_0000_0000, 32'h8000_0000, 48'h8000_0000_0000), 1'b1));
        dir_rows.push_back(make_row(DELTA_TOP, make_cell(0, 32'h1_0000, 48'h0, 32'h1_0000,
                           48'h0), 1'b0));
        dir_rows.push_back(make_row(DELTA_TOP, make_cell(0, 32'h2_0000, 48'h0, 32'h3_0000,
                           48'h0), 1'b0));
        dir_rows.push_back(make_row(DELTA_TOP, make_cell(0, 32'h4_0000, 48'h0, 32'h5_0000,
                           48'h0), 1'b1));
        dir_rows.push_back(make_row(DELTA_TOP, make_cell(32'h0003_0000, 32'hFFFF_8000,
                           48'hFFFF_FFFE_8000, 32'h0000_8000, 48'h1_8000), 1'b0));
        dir_rows.push_back(make_row(DELTA_TOP, make_cell(32'h0000_0001, 32'h0001_0000, 48'h1,
                           32'hFFFF_0000, 48'hFFFF_FFFF_FFFF), 1'b1));
        dir_rows.push_back(make_row(DELTA_ONE, make_cell(32'hFFFF_FFFF, 32'h0123_4567,
                           48'h1234_5678_9ABC, 32'hFEDC_BA98, 48'hEDCB_A987_6543), 1'b0));
        dir_rows.push_back(make_row(DELTA_ONE, make_cell(32'h0001_0000, 32'h7FFF_FFFF,
                           48'h7FFF_0000, 32'h8000_0000, 48'hFFFF_8000_0000), 1'b0));
        dir_rows.push_back(make_row(DELTA_ONE, make_cell(32'h8000_0000, 0, 48'h0, 0, 48'h0),
                                    1'b1));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].delta != delta_rate)
            begin
                drain_results();
                write_delta(dir_rows[i].delta);
            end
            send_cell(dir_rows[i].stim, dir_rows[i].last);
            if (dir_rows[i].typed)
                pending_results[$] = dir_rows[i].result;
        end

        phase_delta = '{DELTA_ZERO, DELTA_TOP, DELTA_ONE, DELTA_ZERO, DELTA_ZERO, DELTA_TOP,
                        DELTA_ZERO, DELTA_ZERO};
        for (int p = 0; p < 8; p++)
        begin
            drain_results();
            write_delta((p == 3 || p == 4 || p >= 6) ? DW'($urandom) : phase_delta[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            phase_num = p;
            sent = 0;
            while (sent < 192)
            begin
                if (p == 5 && sent >= 90 && sent < 100)
                begin
                    // pause the sender until the block has delivered everything owed
                    @(negedge clk);
                    cell_in_bus.valid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                    sent = 100;
                end
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    send_cell(rand_cell(), k == len - 1);
                sent += len;
            end
        end

        drain_results();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
